// ----- rtl/fsmr_pkg.sv -----
`timescale 1ns / 1ps

package fsmr_pkg;

    // Payload buffer geometry
    localparam int PAYLOAD_DEPTH = 256;
    localparam int PAYLOAD_AW    = $clog2(PAYLOAD_DEPTH);

    // Register reset values
    localparam logic [7:0] START_CHAR_RST = 8'h02;
    localparam logic [7:0] END_CHAR_RST   = 8'h03;

    // Configuration register indexes
    localparam logic [7:0] CFG_START_CHAR = 8'd0;
    localparam logic [7:0] CFG_END_CHAR   = 8'd1;

    // Request operations
    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_READ    = 2'd1,
        OP_RESYNC  = 2'd2
    } t_opcode;

    // Frame parser states
    typedef enum logic [2:0] {
        PS_IDLE    = 3'd0,
        PS_START   = 3'd1,
        PS_COMMAND = 3'd2,
        PS_LENGTH  = 3'd3,
        PS_DATA    = 3'd4,
        PS_END     = 3'd5
    } t_parser_state;

endpackage

// ----- rtl/framed_serial_message_receiver_core.sv -----
`timescale 1ns / 1ps

// Framed serial message receiver.
// Input channel (i_in_valid / o_in_stall) carries one request per cycle while o_in_stall is low:
// a received serial byte, a read of one stored payload byte, or a resync
// of the parser to idle. Frames have the form start, start, command,
// length, payload, end; payload bytes are written into a 256-entry
// synchronous RAM at positions counted from 0.
// Output channel (o_out_valid / i_out_stall) returns exactly one result
// per request: frame status, last command and length, the read byte and
// a flag that the request completed a valid frame.
// From accept to result a request passes the middle stage, holding the
// parser step and the RAM read port, then the output register. Throughput
// is one request per cycle while o_in_stall is low; the single RAM port
// pair (one write, one registered read) sets that figure.
// The configuration port (i_cfg_valid / o_cfg_ready, always ready) sets
// the start and end characters; the user must write it only while the block is idle; the block does not check.
// Synchronous reset clears the parser, the status and both pipeline
// stages; RAM contents are undefined until written by a frame.
// When the receiver stalls, the result holds in the output register, one
// more request fills the middle stage, and then o_in_stall rises.
module framed_serial_message_receiver_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_read_index,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_frame_ready,
    output logic [7:0] o_frame_command,
    output logic [7:0] o_frame_length,
    output logic [7:0] o_read_byte,
    output logic       o_frame_done,
    // configuration channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import fsmr_pkg::*;

    // configuration
    logic [7:0] r_start_char;
    logic [7:0] r_end_char;

    // parser state
    t_parser_state r_state, n_state;
    logic [7:0]    r_command, n_command;
    logic [7:0]    r_length, n_length;
    logic [7:0]    r_index, n_index;
    logic          r_new, n_new;
    logic          w_done;
    logic          w_wr_en;
    logic          w_rd_en;
    logic [7:0]    w_index_inc;

    // payload RAM
    logic [7:0] r_payload [PAYLOAD_DEPTH];
    logic [7:0] r_mem_q;

    // middle stage
    logic       r_s1_valid;
    logic       r_s1_ready;
    logic [7:0] r_s1_command;
    logic [7:0] r_s1_length;
    logic       r_s1_read;
    logic       r_s1_done;

    // output stage
    logic       r_out_valid;
    logic       r_out_ready;
    logic [7:0] r_out_command;
    logic [7:0] r_out_length;
    logic [7:0] r_out_read;
    logic       r_out_done;

    logic w_accept;
    logic w_out_free;
    logic w_s1_adv;
    t_opcode w_op;

    // handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_adv   = r_s1_valid && w_out_free;
    assign o_in_stall = r_s1_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_op       = t_opcode'(i_opcode);
    assign o_cfg_ready = 1'b1;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= START_CHAR_RST;
            r_end_char   <= END_CHAR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_START_CHAR) begin
                r_start_char <= i_cfg_data;
            end else if (i_cfg_index == CFG_END_CHAR) begin
                r_end_char <= i_cfg_data;
            end
        end
    end

    assign w_index_inc = r_index + 8'd1;

    // parser next state and buffer controls
    always_comb begin
        n_state   = r_state;
        n_command = r_command;
        n_length  = r_length;
        n_index   = r_index;
        n_new     = r_new;
        w_done    = 1'b0;
        w_wr_en   = 1'b0;
        w_rd_en   = 1'b0;
        unique case (w_op)
            OP_RX_BYTE: begin
                unique case (r_state)
                    PS_IDLE: begin
                        n_state = (i_rx_byte == r_start_char) ? PS_START : PS_IDLE;
                    end
                    PS_START: begin
                        n_state = (i_rx_byte == r_start_char) ? PS_COMMAND : PS_IDLE;
                    end
                    PS_COMMAND: begin
                        if (i_rx_byte == r_start_char || i_rx_byte == r_end_char) begin
                            n_state = PS_IDLE;
                        end else begin
                            n_command = i_rx_byte;
                            n_state   = PS_LENGTH;
                        end
                    end
                    PS_LENGTH: begin
                        n_length = i_rx_byte;
                        n_index  = 8'd0;
                        n_state  = PS_DATA;
                    end
                    PS_DATA: begin
                        w_wr_en = ({1'b0, r_index} < 9'(PAYLOAD_DEPTH));
                        n_index = w_index_inc;
                        if (r_length == 8'd0 || w_index_inc >= r_length) begin
                            n_state = PS_END;
                        end
                    end
                    PS_END: begin
                        if (i_rx_byte == r_end_char) begin
                            n_new  = 1'b1;
                            w_done = 1'b1;
                        end else begin
                            n_new = 1'b0;
                        end
                        n_state = PS_IDLE;
                    end
                    default: begin
                        n_state = PS_IDLE;
                    end
                endcase
            end
            OP_READ: begin
                w_rd_en = ({1'b0, i_read_index} < 9'(PAYLOAD_DEPTH));
            end
            OP_RESYNC: begin
                n_state = PS_IDLE;
            end
            default: begin
            end
        endcase
    end

    // advance parser registers on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= PS_IDLE;
            r_command <= 8'd0;
            r_length  <= 8'd0;
            r_index   <= 8'd0;
            r_new     <= 1'b0;
        end else if (w_accept) begin
            r_state   <= n_state;
            r_command <= n_command;
            r_length  <= n_length;
            r_index   <= n_index;
            r_new     <= n_new;
        end
    end

    // payload RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_accept && w_wr_en) begin
            r_payload[r_index[PAYLOAD_AW-1:0]] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_rd_en) begin
            r_mem_q <= r_payload[i_read_index[PAYLOAD_AW-1:0]];
        end
    end

    // middle stage: status after the update, waits for read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_ready   <= n_new;
            r_s1_command <= n_new ? n_command : 8'd0;
            r_s1_length  <= n_length;
            r_s1_read    <= w_rd_en;
            r_s1_done    <= w_done;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_ready   <= r_s1_ready;
            r_out_command <= r_s1_command;
            r_out_length  <= r_s1_length;
            r_out_read    <= r_s1_read ? r_mem_q : 8'd0;
            r_out_done    <= r_s1_done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_ready   = r_out_ready;
    assign o_frame_command = r_out_command;
    assign o_frame_length  = r_out_length;
    assign o_read_byte     = r_out_read;
    assign o_frame_done    = r_out_done;

endmodule

// ----- tb/framed_serial_message_receiver_core_tb.sv -----
`timescale 1ns / 1ps

module framed_serial_message_receiver_core_tb;
    import fsmr_pkg::*;

    // Opcode and register index that the block must ignore
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [7:0] CFG_UNUSED = 8'd2;

    localparam int LONG_HOLD    = 300;
    localparam int STUCK_LIMIT  = 4000;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_ITEMS  = 160;
    localparam int NUM_DIRECTED = 26;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx;
        logic [7:0] idx;
    } t_request;

    typedef struct packed {
        logic       ready;
        logic [7:0] command;
        logic [7:0] length;
        logic [7:0] rdata;
        logic       done;
    } t_result;

    typedef struct packed {
        t_request req;
        logic     typed;
        t_result  want;
    } t_directed_row;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_opcode     = 2'd0;
    logic [7:0] i_rx_byte    = 8'd0;
    logic [7:0] i_read_index = 8'd0;
    logic       o_out_valid;
    logic       i_out_stall  = 1'b0;
    logic       o_frame_ready;
    logic [7:0] o_frame_command;
    logic [7:0] o_frame_length;
    logic [7:0] o_read_byte;
    logic       o_frame_done;
    logic       i_cfg_valid  = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_index  = 8'd0;
    logic [7:0] i_cfg_data   = 8'd0;

    framed_serial_message_receiver_core u_top (.*);

    always #2 i_clk = ~i_clk;

    // Mirror of the parser state and configuration
    t_parser_state parse_state = PS_IDLE;
    logic [7:0] cfg_start = START_CHAR_RST;
    logic [7:0] cfg_end   = END_CHAR_RST;
    logic [7:0] command_q = 8'd0;
    logic [7:0] length_q  = 8'd0;
    logic [7:0] position_q = 8'd0;
    logic       frame_flag = 1'b0;
    logic [7:0] payload_mirror [PAYLOAD_DEPTH];
    int         highest_written = -1;

    t_result pending_results [$];
    int  mismatches = 0;
    int  requests_sent = 0;
    int  stuck_cycles = 0;
    bit  sender_burst = 1'b0;
    bit  receiver_burst = 1'b0;
    bit  hold_request = 1'b0;

    // Directed requests under the reset characters
    t_directed_row directed_rows [NUM_DIRECTED] = '{
        '{'{OP_UNUSED,  8'h00, 8'h00}, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0}},
        '{'{OP_RESYNC,  8'hFF, 8'hFF}, 1'b1, '{1'b0, 8'h00, 8'h00, 8'h00, 1'b0}},
        // command equal to the start character
        '{'{OP_RX_BYTE, 8'h02, 8'hFF}, 1'b0, '0},
        '{'{OP_RX_BYTE, 8'h02, 8'h00}, 1'b0, '0},
        '{'{OP_RX_BYTE, 8'h02, 8'hFF}, 1'b0, '0},
        // command equal to the end character
        '{'{OP_RX_BYTE, 8'h02, 8'h00}, 1'b0, '0},
        '{'{OP_RX_BYTE, 8'h02, 8'hFF}, 1'b0, '0},
        '{'{OP_RX_BYTE, 8'h03, 8'h00}, 1'b0, '0},
        // zero length still takes one payload byte
        '{'{OP_RX_BYTE, 8'h02, 8'hFF}, 1'b0, '0},
        '{'{OP_RX_BYTE, 8'h02, 8'h00}, 1'b0, '0},
        '{'{OP_RX_BYTE, 8'hFF, 8'hFF}, 1'b0, '0},
        '{'{OP_RX_BYTE, 8'h00, 8'h00}, 1'b0, '0},
        '{'{OP_RX_BYTE, 8'h00, 8'hFF}, 1'b0, '0},
        '{'{OP_RX_BYTE, 8'h03, 8'h00}, 1'b1, '{1'b1, 8'hFF, 8'h00, 8'h00, 1'b1}},
        '{'{OP_READ,    8'hAA, 8'h00}, 1'b1, '{1'b1, 8'hFF, 8'h00, 8'h00, 1'b0}},
        '{'{OP_UNUSED,  8'h55, 8'h12}, 1'b1, '{1'b1, 8'hFF, 8'h00, 8'h00, 1'b0}},
        // bad end clears the flag, command still overwritten
        '{'{OP_RX_BYTE, 8'h02, 8'hFF}, 1'b0, '0},
        '{'{OP_RX_BYTE, 8'h02, 8'h00}, 1'b0, '0},
        '{'{OP_RX_BYTE, 8'h00, 8'hFF}, 1'b0, '0},
        '{'{OP_RX_BYTE, 8'h01, 8'h00}, 1'b0, '0},
        '{'{OP_RX_BYTE, 8'hFF, 8'hFF}, 1'b0, '0},
        '{'{OP_RX_BYTE, 8'h00, 8'h00}, 1'b1, '{1'b0, 8'h00, 8'h01, 8'h00, 1'b0}},
        '{'{OP_READ,    8'h00, 8'h00}, 1'b1, '{1'b0, 8'h00, 8'h01, 8'hFF, 1'b0}},
        // resync in the middle of the start sequence
        '{'{OP_RX_BYTE, 8'h02, 8'hFF}, 1'b0, '0},
        '{'{OP_RX_BYTE, 8'h02, 8'h00}, 1'b0, '0},
        '{'{OP_RESYNC,  8'h02, 8'hFF}, 1'b0, '0}
    };

    // Advance the mirror by one request and return the status it reports
    function automatic t_result predict_status(t_request r);
        t_result res;
        res = '0;
        case (r.op)
            OP_RX_BYTE: begin
                case (parse_state)
                    PS_IDLE:  parse_state = (r.rx == cfg_start) ? PS_START : PS_IDLE;
                    PS_START: parse_state = (r.rx == cfg_start) ? PS_COMMAND : PS_IDLE;
                    PS_COMMAND: begin
                        if (r.rx == cfg_start || r.rx == cfg_end) begin
                            parse_state = PS_IDLE;
                        end else begin
                            command_q   = r.rx;
                            parse_state = PS_LENGTH;
                        end
                    end
                    PS_LENGTH: begin
                        length_q    = r.rx;
                        position_q  = 8'd0;
                        parse_state = PS_DATA;
                    end
                    PS_DATA: begin
                        // drop bytes past the buffer but keep counting them
                        if (int'(position_q) < PAYLOAD_DEPTH) begin
                            payload_mirror[position_q] = r.rx;
                            if (int'(position_q) > highest_written)
                                highest_written = int'(position_q);
                        end
                        position_q = position_q + 8'd1;
                        if (length_q == 8'd0 || position_q >= length_q) parse_state = PS_END;
                    end
                    PS_END: begin
                        frame_flag  = (r.rx == cfg_end);
                        res.done    = frame_flag;
                        parse_state = PS_IDLE;
                    end
                    default: parse_state = PS_IDLE;
                endcase
            end
            OP_READ: begin
                if (int'(r.idx) < PAYLOAD_DEPTH) res.rdata = payload_mirror[r.idx];
            end
            OP_RESYNC: parse_state = PS_IDLE;
            default: ;
        endcase
        res.ready   = frame_flag;
        res.command = frame_flag ? command_q : 8'd0;
        res.length  = length_q;
        return res;
    endfunction

    // Offer one request after a random gap and record its expected status
    task automatic send_request(t_request r, bit typed, t_result typed_res);
        int gap;
        t_result res;
        gap = sender_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= r.op;
        i_rx_byte    <= r.rx;
        i_read_index <= r.idx;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        res = predict_status(r);
        pending_results.push_back(typed ? typed_res : res);
        if (r.op != OP_UNUSED) requests_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_request('{OP_RX_BYTE, b, 8'($urandom)}, 1'b0, '0);
    endtask

    // Read only positions that some frame has written
    task automatic send_read();
        send_request('{OP_READ, 8'($urandom), 8'($urandom_range(0, highest_written))},
                     1'b0, '0);
    endtask

    // Hold the input and wait for every outstanding status
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Write both characters, then an index the block must ignore
    task automatic program_chars(logic [7:0] start_value, logic [7:0] end_value);
        logic [7:0] indexes [3];
        logic [7:0] values [3];
        indexes = '{CFG_START_CHAR, CFG_END_CHAR, CFG_UNUSED};
        values  = '{start_value, end_value, 8'($urandom)};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= indexes[k];
            i_cfg_data  <= values[k];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            if (indexes[k] == CFG_START_CHAR) cfg_start = values[k];
            else if (indexes[k] == CFG_END_CHAR) cfg_end = values[k];
        end
        i_cfg_valid <= 1'b0;
    endtask

    // One frame with random content, sometimes broken on purpose
    task automatic send_frame();
        int flaw;
        int len_draw;
        int count;
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] tail;
        flaw = $urandom_range(0, 99);
        send_byte(cfg_start);
        send_byte(cfg_start);
        if (flaw < 5) begin
            send_byte($urandom_range(0, 1) ? cfg_start : cfg_end);
            return;
        end
        do cmd = 8'($urandom); while (cmd == cfg_start || cmd == cfg_end);
        send_byte(cmd);
        len_draw = $urandom_range(0, 199);
        if (len_draw < 2) len = 8'd255;
        else if (len_draw < 20) len = 8'($urandom_range(16, 64));
        else len = 8'($urandom_range(0, 8));
        send_byte(len);
        count = (len == 8'd0) ? 1 : int'(len);
        for (int i = 0; i < count; i++) begin
            if (highest_written >= 0 && $urandom_range(0, 9) == 0) send_read();
            if (flaw < 10 && i == count / 2) begin
                send_request('{OP_RESYNC, 8'($urandom), 8'($urandom)}, 1'b0, '0);
                return;
            end
            send_byte(8'($urandom));
        end
        if (flaw < 25) begin
            do tail = 8'($urandom); while (tail == cfg_end);
        end else begin
            tail = cfg_end;
        end
        send_byte(tail);
    endtask

    // Mixed traffic until the phase quota of requests is sent
    task automatic send_traffic(int quota);
        int action;
        int target;
        target = requests_sent + quota;
        while (requests_sent < target) begin
            if ($urandom_range(0, 19) == 0) sender_burst = !sender_burst;
            action = $urandom_range(0, 99);
            if (action < 60) send_frame();
            else if (action < 78 && highest_written >= 0) send_read();
            else if (action < 90) send_byte(8'($urandom));
            else if (action < 95)
                send_request('{OP_RESYNC, 8'($urandom), 8'($urandom)}, 1'b0, '0);
            else send_request('{OP_UNUSED, 8'($urandom), 8'($urandom)}, 1'b0, '0);
        end
    endtask

    // Accept results with random stalls and compare each field
    initial begin : result_sink
        int hold;
        t_result want;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold = LONG_HOLD;
                hold_request = 1'b0;
            end else begin
                hold = receiver_burst ? 0 : $urandom_range(0, 15);
            end
            if ($urandom_range(0, 49) == 0) receiver_burst = !receiver_burst;
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_frame_ready !== want.ready) begin
                    $error("frame_ready: expected %0h, got %0h", want.ready, o_frame_ready);
                    mismatches++;
                end
                if (o_frame_command !== want.command) begin
                    $error("frame_command: expected %0h, got %0h",
                           want.command, o_frame_command);
                    mismatches++;
                end
                if (o_frame_length !== want.length) begin
                    $error("frame_length: expected %0h, got %0h", want.length, o_frame_length);
                    mismatches++;
                end
                if (o_read_byte !== want.rdata) begin
                    $error("read_byte: expected %0h, got %0h", want.rdata, o_read_byte);
                    mismatches++;
                end
                if (o_frame_done !== want.done) begin
                    $error("frame_done: expected %0h, got %0h", want.done, o_frame_done);
                    mismatches++;
                end
            end
        end
    end

    // End the run when no channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("framed_serial_message_receiver_core verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] phase_start [NUM_PHASES];
        logic [7:0] phase_end [NUM_PHASES];
        phase_start = '{8'h02, 8'h00, 8'hFF, 8'($urandom), 8'h5A};
        phase_end   = '{8'h03, 8'hFF, 8'h00, 8'($urandom), 8'h5A};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        program_chars(START_CHAR_RST, END_CHAR_RST);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            program_chars(phase_start[p], phase_end[p]);
            // fill the block against a long receiver hold-off
            if (p == 1) begin
                sender_burst = 1'b1;
                hold_request = 1'b1;
            end
            send_traffic(PHASE_ITEMS);
        end
        drain_results();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("framed_serial_message_receiver_core verification clean");
        else
            $display("framed_serial_message_receiver_core verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/fsmr_pkg.sv
rtl/framed_serial_message_receiver_core.sv
tb/framed_serial_message_receiver_core_tb.sv
